// ===== src/ppur_pkg.sv =====
// Shared types and constants for the particle pool update and render block.
package ppur_pkg;

	typedef enum logic [1:0] {
		OP_EMIT   = 2'd0,
		OP_TICK   = 2'd1,
		OP_RENDER = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// Rotation rate of 0.01 rad/s in Q16.16
	localparam logic [9:0] ROT_RATE_Q16 = 10'd655;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic [18:0]        start_angle;
		logic [30:0]        size_start;
		logic [30:0]        size_final;
		logic [30:0]        lifespan;
		logic [31:0]        rgba_start;
		logic [31:0]        rgba_final;
		logic [30:0]        step_time;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] draw_x;
		logic signed [31:0] draw_y;
		logic signed [31:0] draw_angle;
		logic [30:0]        draw_size;
		logic [31:0]        draw_rgba;
		logic               last;
	} out_item_t;

	// Back-end walk states
	typedef enum logic [3:0] {
		BK_IDLE,
		BK_READ,
		BK_MUL1,
		BK_MUL2,
		BK_WRITE,
		BK_DIV,
		BK_LERP,
		BK_ALPHA,
		BK_SCAN
	} bk_state_t;

	// Saturate a 49-bit signed sum to 32 bits
	function automatic logic [31:0] sat32(input logic signed [48:0] x);
		logic [31:0] r;
		if (x > 49'sd2147483647) r = 32'h7FFF_FFFF;
		else if (x < -49'sd2147483648) r = 32'h8000_0000;
		else r = x[31:0];
		return r;
	endfunction

	function automatic logic [7:0] clamp8(input logic signed [10:0] v);
		logic [7:0] r;
		if (v < 0) r = 8'd0;
		else if (v > 11'sd255) r = 8'd255;
		else r = v[7:0];
		return r;
	endfunction

endpackage

// ===== src/ppur_front.sv =====
// Front end: accepts commands and queues them for the pool engine.
module ppur_front import ppur_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  in_item_t cmd,
	output logic     busy,
	output logic     q_valid,
	output in_item_t q_item,
	input  logic     q_pop
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	in_item_t         mem_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [AW:0]      cnt_q;
	logic             push;

	// Unused op codes are dropped here
	assign busy    = (cnt_q == (AW+1)'(DEPTH));
	assign push    = start && !busy && (op_t'(cmd.op) != OP_NONE);
	assign q_valid = (cnt_q != '0);
	assign q_item  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= cmd;
	end

	// Queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			if (q_pop) rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(q_pop);
		end
	end
endmodule

// ===== src/ppur_div.sv =====
// Restoring divider for the life fraction, one quotient bit per cycle.
module ppur_div import ppur_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [30:0] num,
	input  logic [30:0] den,
	output logic        done,
	output logic [16:0] quo
);
	logic [31:0] rem_q;
	logic [16:0] quo_q;
	logic [4:0]  cnt_q;
	logic        run_q;
	logic [31:0] trial;

	assign trial = {rem_q[30:0], 1'b0} - {1'b0, den};
	assign quo   = quo_q;
	assign done  = run_q && (cnt_q == 5'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (go) begin
			run_q <= 1'b1;
			cnt_q <= 5'd16;
		end else if (run_q) begin
			if (cnt_q == 5'd0) run_q <= 1'b0;
			else cnt_q <= cnt_q - 1'b1;
		end
	end

	// num < den, so quotient of num<<16 fits 16 bits
	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= {1'b0, num};
			quo_q <= '0;
		end else if (run_q && cnt_q != 5'd0) begin
			if (!trial[31]) begin
				rem_q <= trial;
				quo_q <= {quo_q[15:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], 1'b0};
				quo_q <= {quo_q[15:0], 1'b0};
			end
		end
	end
endmodule

// ===== src/ppur_back.sv =====
// Back end: pool storage, tick update walk and render walk.
module ppur_back import ppur_pkg::*; #(
	parameter int POOL_SIZE = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	input  in_item_t  q_item,
	output logic      q_pop,
	output logic      result_valid,
	output out_item_t result
);
	localparam int IW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;

	// Pool memories, one read/write port each
	logic [31:0]  px_m [POOL_SIZE];
	logic [31:0]  py_m [POOL_SIZE];
	logic [31:0]  vx_m [POOL_SIZE];
	logic [31:0]  vy_m [POOL_SIZE];
	logic [31:0]  ang_m [POOL_SIZE];
	logic [31:0]  ll_m [POOL_SIZE];
	logic [30:0]  lt_m [POOL_SIZE];
	logic [61:0]  sz_m [POOL_SIZE];
	logic [63:0]  col_m [POOL_SIZE];
	logic [POOL_SIZE-1:0] alive_q;

	bk_state_t    st_q, st_d;
	logic [IW-1:0] idx_q, slot_q;
	logic         is_tick_q;
	logic [30:0]  dt_q;
	logic         emit_now;

	// Registered read data
	logic [31:0] rpx_q, rpy_q, rvx_q, rvy_q, rang_q, rll_q;
	logic [30:0] rlt_q;
	logic [61:0] rsz_q;
	logic [63:0] rcol_q;

	// Product registers
	logic signed [63:0] mx_q, my_q;
	logic [16:0]        f_q;
	logic signed [48:0] dsz_q;
	logic signed [25:0] dch_q [4];
	logic [7:0]         ch_q [4];
	logic [30:0]        size_q;

	logic        div_go, div_done;
	logic [16:0] div_quo;
	logic        more_alive;
	logic        at_end;

	ppur_div u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go),
		.num(rll_q[30:0]), .den(rlt_q), .done(div_done), .quo(div_quo)
	);

	assign at_end   = (idx_q == IW'(POOL_SIZE-1));
	assign emit_now = (st_q == BK_IDLE) && q_valid && (op_t'(q_item.op) == OP_EMIT);

	// Any live slot above the current index
	always_comb begin
		more_alive = 1'b0;
		for (int i = 0; i < POOL_SIZE; i++)
			if (alive_q[i] && (IW+1)'(i) > {1'b0, idx_q}) more_alive = 1'b1;
	end

	// Life fraction needs the divider only in the strict interior case
	function automatic logic div_go_needed();
		return !rll_q[31] && (rll_q != '0) && (rll_q[30:0] < rlt_q);
	endfunction

	// Next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			BK_IDLE: if (q_valid && op_t'(q_item.op) != OP_EMIT) st_d = BK_SCAN;
			BK_SCAN: st_d = alive_q[idx_q] ? BK_READ :
					(at_end ? BK_IDLE : BK_SCAN);
			BK_READ: st_d = is_tick_q ? BK_MUL1 : BK_DIV;
			BK_MUL1: st_d = BK_WRITE;
			BK_MUL2: st_d = BK_WRITE;
			BK_WRITE: st_d = at_end ? BK_IDLE : BK_SCAN;
			BK_DIV: if (div_done || !div_go_needed()) st_d = BK_LERP;
			BK_LERP: st_d = BK_ALPHA;
			BK_ALPHA: st_d = at_end ? BK_IDLE : BK_SCAN;
			default: st_d = BK_IDLE;
		endcase
	end

	logic div_started_q;
	assign div_go = (st_q == BK_DIV) && !div_started_q && div_go_needed();
	assign q_pop  = emit_now || ((st_q == BK_IDLE) && q_valid && st_d == BK_SCAN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= BK_IDLE;
			idx_q         <= '0;
			slot_q        <= IW'(POOL_SIZE-1);
			alive_q       <= '0;
			is_tick_q     <= 1'b0;
			div_started_q <= 1'b0;
			result_valid  <= 1'b0;
		end else begin
			st_q         <= st_d;
			result_valid <= 1'b0;
			div_started_q <= (st_q == BK_DIV) && (div_started_q || div_go);
			if (emit_now) begin
				alive_q[slot_q] <= 1'b1;
				slot_q <= (slot_q == '0) ? IW'(POOL_SIZE-1) : slot_q - 1'b1;
			end
			if (st_q == BK_IDLE && q_valid && op_t'(q_item.op) != OP_EMIT) begin
				idx_q     <= '0;
				is_tick_q <= (op_t'(q_item.op) == OP_TICK);
			end
			if ((st_q == BK_SCAN && !alive_q[idx_q] && !at_end) ||
			    (st_q == BK_WRITE && !at_end) || (st_q == BK_ALPHA && !at_end))
				idx_q <= idx_q + 1'b1;
			// Tick clears expired particles
			if (st_q == BK_MUL1 && ($signed(rll_q) <= 0)) alive_q[idx_q] <= 1'b0;
			if (st_q == BK_ALPHA) result_valid <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == BK_ALPHA) begin
			result.draw_x     <= rpx_q;
			result.draw_y     <= rpy_q;
			result.draw_angle <= rang_q;
			result.draw_size  <= size_q;
			result.draw_rgba  <= {ch_q[3], ch_q[2], ch_q[1],
				clamp8(11'($signed({1'b0, 26'({18'd0, ch_q[0]} * f_q)}) >>> 16))};
			result.last       <= !more_alive;
		end
	end

	// Emit write and tick writeback
	always_ff @(posedge clk) begin
		if (emit_now) begin
			px_m[slot_q]  <= q_item.pos_x;
			py_m[slot_q]  <= q_item.pos_y;
			vx_m[slot_q]  <= q_item.vel_x;
			vy_m[slot_q]  <= q_item.vel_y;
			ang_m[slot_q] <= {13'd0, q_item.start_angle};
			ll_m[slot_q]  <= {1'b0, q_item.lifespan};
			lt_m[slot_q]  <= q_item.lifespan;
			sz_m[slot_q]  <= {q_item.size_start, q_item.size_final};
			col_m[slot_q] <= {q_item.rgba_start, q_item.rgba_final};
		end else if (st_q == BK_WRITE) begin
			ll_m[idx_q]  <= sat32(49'($signed(rll_q)) - 49'($signed({1'b0, dt_q})));
			px_m[idx_q]  <= sat32(49'($signed(rpx_q)) + 49'(mx_q >>> 16));
			py_m[idx_q]  <= sat32(49'($signed(rpy_q)) + 49'(my_q >>> 16));
			ang_m[idx_q] <= sat32(49'($signed(rang_q)) +
				49'(({10'd0, dt_q} * 41'(ROT_RATE_Q16)) >> 16));
		end
		if (st_q == BK_IDLE && q_valid) dt_q <= q_item.step_time;
		if (st_q == BK_SCAN) begin
			rpx_q  <= px_m[idx_q];
			rpy_q  <= py_m[idx_q];
			rvx_q  <= vx_m[idx_q];
			rvy_q  <= vy_m[idx_q];
			rang_q <= ang_m[idx_q];
			rll_q  <= ll_m[idx_q];
			rlt_q  <= lt_m[idx_q];
			rsz_q  <= sz_m[idx_q];
			rcol_q <= col_m[idx_q];
		end
		// velocity times timestep, 32x31 product
		if (st_q == BK_READ) begin
			mx_q <= $signed(rvx_q) * $signed({1'b0, dt_q});
			my_q <= $signed(rvy_q) * $signed({1'b0, dt_q});
		end
		// life fraction
		if (st_q == BK_DIV && st_d == BK_LERP) begin
			if ($signed(rll_q) <= 0) f_q <= '0;
			else if (rll_q[30:0] >= rlt_q) f_q <= 17'h10000;
			else f_q <= div_quo;
		end
		// lerp products, floor shift after
		if (st_q == BK_LERP) begin
			dsz_q <= ($signed({1'b0, rsz_q[61:31]}) - $signed({1'b0, rsz_q[30:0]}))
				* $signed({1'b0, f_q});
			for (int c = 0; c < 4; c++)
				dch_q[c] <= ($signed({1'b0, rcol_q[32+8*c +: 8]}) -
					$signed({1'b0, rcol_q[8*c +: 8]})) * $signed({1'b0, f_q});
		end
	end

	// Final lerp sums, consumed in BK_ALPHA
	always_comb begin
		size_q = 31'($signed({1'b0, rsz_q[30:0]}) + (dsz_q >>> 16));
		for (int c = 0; c < 4; c++)
			ch_q[c] = clamp8(11'($signed({1'b0, rcol_q[8*c +: 8]}) + (dch_q[c] >>> 16)));
	end
endmodule

// ===== src/particle_pool_update_render.sv =====
// Top level: particle ring pool with tick update and render walk.
// Emit stores the command into the next write slot. Tick walks every slot, updating live ones.
// Render walks every slot; a live slot that needs the 16-step divider waits for it.
// One result per cycle at most; results carry a strobe and cannot be stalled.
// Reset clears all live flags and sets the write slot to the top slot; pool memories
// are not cleared.
module particle_pool_update_render import ppur_pkg::*; #(
	parameter int POOL_SIZE = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  in_item_t  cmd,
	output logic      busy,
	output logic      result_valid,
	output out_item_t result
);
	logic     q_valid, q_pop;
	in_item_t q_item;

	ppur_front #(.DEPTH(2)) u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd), .busy(busy),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
	);

	ppur_back #(.POOL_SIZE(POOL_SIZE)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_item(q_item),
		.q_pop(q_pop), .result_valid(result_valid), .result(result)
	);

	// Never pop an empty queue
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop from empty queue");
	// Busy only after a transfer filled the queue
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start)) else $error("busy without transfer");
endmodule
